@@ hw/rtl/lsrp_pkg.sv @@
// Shared types and constants for the line-sphere reach point block.
// No dependencies; used by line_sphere_reach_point_core.
package lsrp_pkg;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 24;

  // 0.4 m floor on the point distance, Q8.16
  localparam logic [24:0] MIN_DIST = 25'd26214;
  // 0.6 m default reach radius, Q8.16
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd39322;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_EQ_X   = 2'd1;
  localparam logic [1:0] STATUS_NO_HIT = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] centre_z;
  } lsrp_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] reach_x;
    logic signed [COORD_W-1:0] reach_y;
    logic signed [COORD_W-1:0] reach_z;
    logic [1:0]                status;
  } lsrp_out_t;

endpackage

@@ hw/rtl/lsrp_dly.sv @@
// Valid bit plus sideband delay line, one register per stage.
// Standalone; matches the latency of the arithmetic units it runs beside.
module lsrp_dly #(
  parameter int DEPTH = 2,
  parameter int W     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         v_in,
  input  logic [W-1:0] d_in,
  output logic         v_out,
  output logic [W-1:0] d_out
);

  logic         v_r [DEPTH];
  logic [W-1:0] d_r [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_stage
    logic         v_nxt;
    logic [W-1:0] d_nxt;
    if (i == 0) begin : g_first
      assign v_nxt = v_in;
      assign d_nxt = d_in;
    end else begin : g_next
      assign v_nxt = v_r[i-1];
      assign d_nxt = d_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i] <= d_nxt;
      end
    end
  end

  assign v_out = v_r[DEPTH-1];
  assign d_out = d_r[DEPTH-1];

endmodule

@@ hw/rtl/lsrp_mul.sv @@
// Two-stage unsigned multiplier: four half-width partial products, then the sum.
// Standalone; advances on en.
module lsrp_mul #(
  parameter int AW = 50,
  parameter int BW = 50
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] prod
);

  localparam int AL  = (AW + 1) / 2;
  localparam int AHW = AW - AL;
  localparam int BL  = (BW + 1) / 2;
  localparam int BHW = BW - BL;
  localparam int PW  = AW + BW;

  logic [AL+BL-1:0]   p_ll_r;
  logic [AL+BHW-1:0]  p_lh_r;
  logic [AHW+BL-1:0]  p_hl_r;
  logic [AHW+BHW-1:0] p_hh_r;
  logic [PW-1:0]      prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll_r <= a[AL-1:0]  * b[BL-1:0];
      p_lh_r <= a[AL-1:0]  * b[BW-1:BL];
      p_hl_r <= a[AW-1:AL] * b[BL-1:0];
      p_hh_r <= a[AW-1:AL] * b[BW-1:BL];
      prod_r <= PW'(p_ll_r) + (PW'(p_lh_r) << BL) + (PW'(p_hl_r) << AL)
              + (PW'(p_hh_r) << (AL + BL));
    end
  end

  assign prod = prod_r;

endmodule

@@ hw/rtl/lsrp_sqrt.sv @@
// Pipelined integer square root, one result bit per stage (floor).
// Standalone; advances on en.
module lsrp_sqrt #(
  parameter int IW = 50
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   rad,
  output logic [IW/2-1:0] root
);

  localparam int OW = IW / 2;
  localparam int RW = OW + 3;

  logic [RW-1:0] rem_r  [OW];
  logic [OW-1:0] root_r [OW];
  logic [IW-1:0] rad_r  [OW];

  for (genvar i = 0; i < OW; i++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [OW-1:0] root_in;
    logic [IW-1:0] rad_in;
    logic [RW-1:0] t;
    logic [RW-1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign t     = {rem_in[RW-3:0], rad_in[IW-1:IW-2]};
    assign trial = RW'({root_in, 2'b01});
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (t - trial) : t;
        root_r[i] <= {root_in[OW-2:0], ge};
        rad_r[i]  <= rad_in << 2;
      end
    end
  end

  assign root = root_r[OW-1];

endmodule

@@ hw/rtl/lsrp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; advances on en. The caller guarantees num < den * 2**QW.
module lsrp_div #(
  parameter int NW = 77,
  parameter int DW = 50,
  parameter int QW = 27
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot,
  output logic [DW-1:0] rem
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   t;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = DW'(num[NW-1:QW]);
      assign lo_in  = num[QW-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign lo_in  = lo_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
    end

    assign t  = {rem_in, lo_in[QW-1]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
        lo_r[i]  <= lo_in << 1;
        quo_r[i] <= {quo_in[QW-2:0], ge};
        den_r[i] <= den_in;
      end
    end
  end

  assign quot = quo_r[QW-1];
  assign rem  = rem_r[QW-1];

endmodule

@@ hw/rtl/line_sphere_reach_point_core.sv @@
// Throughput: one item per cycle unless the skid register is full; the long paths
// are the two square-root pipelines (25 and 51 stages) and the 27-stage dividers, all fully pipelined.
// A stalled output parks one item in a skid register; the pipe then freezes.
// Reset (rst_n low, synchronous) clears all valid bits and the skid full flag and
// sets the radius limit to 0.6 m.
module line_sphere_reach_point_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsrp_pkg::lsrp_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lsrp_pkg::lsrp_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [23:0]         cfg_data
);

  localparam int Q_W    = 50;   // |D|^2, |W|^2
  localparam int P_W    = 51;   // D.W, signed
  localparam int DISC_W = 102;  // discriminant, even for the root unit
  localparam int N_W    = 52;   // |n|
  localparam int K_W    = 25;   // |D component|
  localparam int PROD_W = K_W + N_W;
  localparam int QUO_W  = 27;   // |k*n/q| stays below 2**26

  typedef struct packed {
    logic                 byp;
    logic                 eqx;
    logic                 dxpos;
    logic                 cwpos;
    logic                 negd;
    logic [2:0][23:0]     s;
    logic [2:0][23:0]     e;
    logic [2:0][24:0]     d;
    logic [P_W-1:0]       p;
    logic [Q_W-1:0]       w;
    logic [Q_W-1:0]       q;
  } side_t;

  typedef struct packed {
    logic             byp;
    logic             eqx;
    logic             negd;
    logic [2:0][23:0] s;
    logic [2:0][23:0] e;
    logic [Q_W-1:0]   q;
    logic [2:0]       neg;
  } tail_t;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    logic signed [23:0] res;
    if (v > 30'sd8388607) begin
      res = 24'sh7FFFFF;
    end else if (v < -30'sd8388608) begin
      res = -24'sh800000;
    end else begin
      res = v[23:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- config
  logic [23:0] radius_lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_lim_r <= lsrp_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius_lim_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- flow
  // The whole pipe moves together; it freezes only while the skid holds an item,
  // so en comes straight from a register.
  logic skid_full_r;
  logic en;
  logic in_acc;

  assign en       = ~skid_full_r;
  assign in_stall = skid_full_r;
  assign in_acc   = in_valid & ~in_stall;

  // ---------------------------------------------------------------- stage 1
  // D = E - S, W = S - C
  logic signed [23:0] in_s [3];
  logic signed [23:0] in_e [3];
  logic signed [23:0] in_c [3];

  assign in_s[0] = in_item.start_x;
  assign in_s[1] = in_item.start_y;
  assign in_s[2] = in_item.start_z;
  assign in_e[0] = in_item.end_x;
  assign in_e[1] = in_item.end_y;
  assign in_e[2] = in_item.end_z;
  assign in_c[0] = in_item.centre_x;
  assign in_c[1] = in_item.centre_y;
  assign in_c[2] = in_item.centre_z;

  logic               s1_v_r;
  logic signed [23:0] s1_s_r [3];
  logic signed [23:0] s1_e_r [3];
  logic signed [24:0] s1_d_r [3];
  logic signed [24:0] s1_w_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_s_r[i] <= in_s[i];
        s1_e_r[i] <= in_e[i];
        s1_d_r[i] <= {in_e[i][23], in_e[i]} - {in_s[i][23], in_s[i]};
        s1_w_r[i] <= {in_s[i][23], in_s[i]} - {in_c[i][23], in_c[i]};
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  // nine 25x25 products; special-case flags
  logic               s2_v_r;
  logic               s2_byp_r;
  logic               s2_eqx_r;
  logic               s2_dxpos_r;
  logic signed [23:0] s2_s_r  [3];
  logic signed [23:0] s2_e_r  [3];
  logic signed [24:0] s2_d_r  [3];
  logic signed [49:0] s2_dd_r [3];
  logic signed [49:0] s2_ww_r [3];
  logic signed [49:0] s2_dw_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_byp_r   <= (radius_lim_r == '0);
      s2_eqx_r   <= (s1_d_r[0] == '0);
      s2_dxpos_r <= ~s1_d_r[0][24];
      for (int i = 0; i < 3; i++) begin
        s2_s_r[i]  <= s1_s_r[i];
        s2_e_r[i]  <= s1_e_r[i];
        s2_d_r[i]  <= s1_d_r[i];
        s2_dd_r[i] <= s1_d_r[i] * s1_d_r[i];
        s2_ww_r[i] <= s1_w_r[i] * s1_w_r[i];
        s2_dw_r[i] <= s1_d_r[i] * s1_w_r[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  // q = |D|^2, w = |W|^2, p = D.W
  logic     s3_v_r;
  side_t    s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r.byp   <= s2_byp_r;
      s3_side_r.eqx   <= s2_eqx_r;
      s3_side_r.dxpos <= s2_dxpos_r;
      s3_side_r.cwpos <= 1'b0;
      s3_side_r.negd  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        s3_side_r.s[i] <= s2_s_r[i];
        s3_side_r.e[i] <= s2_e_r[i];
        s3_side_r.d[i] <= s2_d_r[i];
      end
      s3_side_r.q <= Q_W'(s2_dd_r[0]) + Q_W'(s2_dd_r[1]) + Q_W'(s2_dd_r[2]);
      s3_side_r.w <= Q_W'(s2_ww_r[0]) + Q_W'(s2_ww_r[1]) + Q_W'(s2_ww_r[2]);
      s3_side_r.p <= P_W'(s2_dw_r[0]) + P_W'(s2_dw_r[1]) + P_W'(s2_dw_r[2]);
    end
  end

  // ---------------------------------------------------------------- |D| root
  logic [Q_W/2-1:0] dist_root;
  logic             sa_v;
  side_t            sa_side;

  lsrp_sqrt #(.IW(Q_W)) u_sqrt_dist (
    .clk  (clk),
    .en   (en),
    .rad  (s3_side_r.q),
    .root (dist_root)
  );

  lsrp_dly #(.DEPTH(Q_W/2), .W($bits(side_t))) u_dly_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (s3_v_r),
    .d_in  (s3_side_r),
    .v_out (sa_v),
    .d_out (sa_side)
  );

  // ---------------------------------------------------------------- stage 4
  // r = min(max(dist, 0.4 m), radius limit)
  logic [24:0] dist_clamp;
  logic [23:0] r_sel;
  logic        s4_v_r;
  logic [23:0] s4_r_r;
  side_t       s4_side_r;

  assign dist_clamp = (dist_root < lsrp_pkg::MIN_DIST) ? lsrp_pkg::MIN_DIST : dist_root;
  assign r_sel = (dist_clamp > {1'b0, radius_lim_r}) ? radius_lim_r : dist_clamp[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= sa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r_r    <= r_sel;
      s4_side_r <= sa_side;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic        s5_v_r;
  logic [47:0] s5_r2_r;
  side_t       s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r2_r   <= s4_r_r * s4_r_r;
      s5_side_r <= s4_side_r;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // cw = w - r^2 as sign and magnitude; |p|
  logic           cwpos;
  logic [P_W-1:0] p_abs;
  side_t          s6_side_nxt;
  logic           s6_v_r;
  logic [Q_W-1:0] s6_cwmag_r;
  logic [Q_W-1:0] s6_pmag_r;
  side_t          s6_side_r;

  assign cwpos = (s5_side_r.w > Q_W'(s5_r2_r));
  assign p_abs = s5_side_r.p[P_W-1] ? (~s5_side_r.p + 1'b1) : s5_side_r.p;

  always_comb begin
    s6_side_nxt       = s5_side_r;
    s6_side_nxt.cwpos = cwpos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_cwmag_r <= cwpos ? (s5_side_r.w - Q_W'(s5_r2_r))
                          : (Q_W'(s5_r2_r) - s5_side_r.w);
      s6_pmag_r  <= p_abs[Q_W-1:0];
      s6_side_r  <= s6_side_nxt;
    end
  end

  // ---------------------------------------------------------------- p^2, q*|cw|
  logic [2*Q_W-1:0] pp;
  logic [2*Q_W-1:0] qc;
  logic             sb_v;
  side_t            sb_side;

  lsrp_mul #(.AW(Q_W), .BW(Q_W)) u_mul_pp (
    .clk  (clk),
    .en   (en),
    .a    (s6_pmag_r),
    .b    (s6_pmag_r),
    .prod (pp)
  );

  lsrp_mul #(.AW(Q_W), .BW(Q_W)) u_mul_qc (
    .clk  (clk),
    .en   (en),
    .a    (s6_side_r.q),
    .b    (s6_cwmag_r),
    .prod (qc)
  );

  lsrp_dly #(.DEPTH(2), .W($bits(side_t))) u_dly_disc (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (s6_v_r),
    .d_in  (s6_side_r),
    .v_out (sb_v),
    .d_out (sb_side)
  );

  // ---------------------------------------------------------------- stage 7
  // disc = p^2 - q*cw; negative means the line misses the sphere
  side_t             s7_side_nxt;
  logic              s7_v_r;
  logic [DISC_W-1:0] s7_disc_r;
  side_t             s7_side_r;

  always_comb begin
    s7_side_nxt      = sb_side;
    s7_side_nxt.negd = sb_side.cwpos && (pp < qc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= sb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_side_r <= s7_side_nxt;
      if (sb_side.cwpos) begin
        s7_disc_r <= DISC_W'(pp - qc);
      end else begin
        s7_disc_r <= DISC_W'(pp) + DISC_W'(qc);
      end
    end
  end

  // ---------------------------------------------------------------- disc root
  logic [DISC_W/2-1:0] disc_root;
  logic                sc_v;
  side_t               sc_side;

  lsrp_sqrt #(.IW(DISC_W)) u_sqrt_disc (
    .clk  (clk),
    .en   (en),
    .rad  (s7_disc_r),
    .root (disc_root)
  );

  lsrp_dly #(.DEPTH(DISC_W/2), .W($bits(side_t))) u_dly_root (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (s7_v_r),
    .d_in  (s7_side_r),
    .v_out (sc_v),
    .d_out (sc_side)
  );

  // ---------------------------------------------------------------- stage 8
  // n = -p +/- sq, picking the root with the larger x; split signs off
  logic signed [N_W:0] px;
  logic signed [N_W:0] sqx;
  logic signed [N_W:0] nsum;
  logic                nneg;
  logic                s8_v_r;
  logic [N_W-1:0]      s8_nmag_r;
  logic [K_W-1:0]      s8_kmag_r [3];
  tail_t               s8_tail_r;

  assign px   = (N_W+1)'($signed(sc_side.p));
  assign sqx  = $signed({2'b00, disc_root});
  assign nsum = sc_side.dxpos ? (sqx - px) : (-px - sqx);
  assign nneg = nsum[N_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= sc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_nmag_r      <= nneg ? N_W'(-nsum) : nsum[N_W-1:0];
      s8_tail_r.byp  <= sc_side.byp;
      s8_tail_r.eqx  <= sc_side.eqx;
      s8_tail_r.negd <= sc_side.negd;
      s8_tail_r.s    <= sc_side.s;
      s8_tail_r.e    <= sc_side.e;
      s8_tail_r.q    <= sc_side.q;
      for (int i = 0; i < 3; i++) begin
        s8_kmag_r[i]     <= sc_side.d[i][24] ? (~sc_side.d[i] + 1'b1) : sc_side.d[i];
        s8_tail_r.neg[i] <= sc_side.d[i][24] ^ nneg;
      end
    end
  end

  // ---------------------------------------------------------------- k*n, /q
  logic [PROD_W-1:0] kn   [3];
  logic [QUO_W-1:0]  quot [3];
  logic [Q_W-1:0]    rem  [3];
  logic              sd_v;
  tail_t             sd_tail;
  logic              se_v;
  tail_t             se_tail;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    lsrp_mul #(.AW(K_W), .BW(N_W)) u_mul_kn (
      .clk  (clk),
      .en   (en),
      .a    (s8_kmag_r[i]),
      .b    (s8_nmag_r),
      .prod (kn[i])
    );

    lsrp_div #(.NW(PROD_W), .DW(Q_W), .QW(QUO_W)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (kn[i]),
      .den  (sd_tail.q),
      .quot (quot[i]),
      .rem  (rem[i])
    );
  end

  lsrp_dly #(.DEPTH(2), .W($bits(tail_t))) u_dly_kn (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (s8_v_r),
    .d_in  (s8_tail_r),
    .v_out (sd_v),
    .d_out (sd_tail)
  );

  lsrp_dly #(.DEPTH(QUO_W), .W($bits(tail_t))) u_dly_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (sd_v),
    .d_in  (sd_tail),
    .v_out (se_v),
    .d_out (se_tail)
  );

  // ---------------------------------------------------------------- stage 11
  // round half away from zero, then reapply the sign
  logic               s11_v_r;
  logic signed [28:0] s11_val_r [3];
  tail_t              s11_tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_v_r <= 1'b0;
    end else if (en) begin
      s11_v_r <= se_v;
    end
  end

  always_ff @(posedge clk) begin : p_round
    logic [27:0] qr;
    if (en) begin
      s11_tail_r <= se_tail;
      for (int i = 0; i < 3; i++) begin
        qr = 28'(quot[i]) + 28'({rem[i], 1'b0} >= {1'b0, se_tail.q});
        s11_val_r[i] <= se_tail.neg[i] ? -29'(qr) : 29'(qr);
      end
    end
  end

  // ---------------------------------------------------------------- stage 12
  // add the start point, saturate, apply the special cases (bypass first)
  lsrp_pkg::lsrp_out_t s12_nxt;
  lsrp_pkg::lsrp_out_t s12_item_r;
  logic                s12_v_r;
  logic signed [23:0]  lane_out [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_out[i] = sat24(30'($signed(s11_tail_r.s[i])) + 30'(s11_val_r[i]));
    end
    s12_nxt.reach_x = lane_out[0];
    s12_nxt.reach_y = lane_out[1];
    s12_nxt.reach_z = lane_out[2];
    s12_nxt.status  = lsrp_pkg::STATUS_OK;
    if (s11_tail_r.byp) begin
      s12_nxt.reach_x = $signed(s11_tail_r.e[0]);
      s12_nxt.reach_y = $signed(s11_tail_r.e[1]);
      s12_nxt.reach_z = $signed(s11_tail_r.e[2]);
    end else if (s11_tail_r.eqx) begin
      s12_nxt.reach_x = '0;
      s12_nxt.reach_y = '0;
      s12_nxt.reach_z = '0;
      s12_nxt.status  = lsrp_pkg::STATUS_EQ_X;
    end else if (s11_tail_r.negd) begin
      s12_nxt.reach_x = '0;
      s12_nxt.reach_y = '0;
      s12_nxt.reach_z = '0;
      s12_nxt.status  = lsrp_pkg::STATUS_NO_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s12_v_r <= 1'b0;
    end else if (en) begin
      s12_v_r <= s11_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s12_item_r <= s12_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  // Output register plus one skid entry. The pipe keeps moving while the
  // output is stalled until an item has to park in the skid.
  lsrp_pkg::lsrp_out_t out_r;
  lsrp_pkg::lsrp_out_t skid_r;
  logic                out_valid_r;
  logic                out_take;

  assign out_take  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_take) begin
        skid_full_r <= 1'b0;
      end
    end else if (s12_v_r) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_full_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (s12_v_r) begin
      if (!out_valid_r || out_take) begin
        out_r <= s12_item_r;
      end else begin
        skid_r <= s12_item_r;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output");

  a_pipe_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (!en && s12_v_r) |=> s12_v_r)
    else $error("last stage item lost while the pipe was frozen");

  a_flagged_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != lsrp_pkg::STATUS_OK) |->
      (out_r.reach_x == '0 && out_r.reach_y == '0 && out_r.reach_z == '0))
    else $error("flagged item carries a nonzero point");

endmodule
